>>> sv/mjs_pkg.sv
`timescale 1ns / 1ps
package mjs_pkg;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [63:0] w64_t;
  typedef logic [2:0]         axis_t;
  typedef logic [30:0]        utime_t;
  typedef logic [15:0]        sidx_t;

  localparam w64_t   LIM     = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam w64_t   ONE_Q32 = 64'sh0000_0001_0000_0000;
  localparam utime_t DUR_RST = 31'd65536;
  localparam utime_t DT_RST  = 31'd656;
  localparam sidx_t  IDX_CAP = 16'd65534;

  localparam logic CFG_DURATION  = 1'b0;
  localparam logic CFG_STEP_TIME = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMING  = 2'd1,
    ST_NO_MOVE = 2'd2
  } status_t;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    KD_NO_AXIS   = 3'd0,
    KD_LOAD_BAD  = 3'd1,
    KD_LOAD_OK   = 3'd2,
    KD_STEP_IDLE = 3'd3,
    KD_STEP_BAD  = 3'd4,
    KD_STEP_OK   = 3'd5
  } kind_t;

  typedef enum logic [4:0] {
    RG_RCP  = 5'd0,
    RG_S1   = 5'd1,
    RG_S2   = 5'd2,
    RG_S3   = 5'd3,
    RG_S4   = 5'd4,
    RG_S5   = 5'd5,
    RG_D    = 5'd6,
    RG_A    = 5'd7,
    RG_B    = 5'd8,
    RG_P    = 5'd9,
    RG_TAU  = 5'd10,
    RG_DT   = 5'd11,
    RG_ACC  = 5'd12,
    RG_POLY = 5'd13,
    RG_T1   = 5'd14,
    RG_T2   = 5'd15,
    RG_ONE  = 5'd16
  } rsel_t;

  typedef enum logic [2:0] {
    OP_MUL  = 3'd0,
    OP_PCLR = 3'd1,
    OP_PACC = 3'd2,
    OP_SADD = 3'd3,
    OP_CLMP = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    SH16 = 3'd0,
    SH17 = 3'd1,
    SH30 = 3'd2,
    SH32 = 3'd3,
    SH46 = 3'd4
  } sh_t;

  typedef logic signed [8:0] kc_t;
  typedef logic [5:0]        upc_t;

  typedef struct packed {
    op_t   op;
    rsel_t dst;
    rsel_t src_a;
    rsel_t src_b;
    sh_t   sh;
    kc_t   k;
  } uop_t;

  localparam upc_t UPC_LAST = 6'd59;

  typedef struct packed {
    logic cap;
    logic rd;
    logic tau;
    logic check;
    logic div_start;
    logic uop_go;
    uop_t uop;
    logic fin;
  } ctl_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  div_done;
    logic  mul_done;
    logic  out_free;
  } dp_sts_t;

  function automatic uop_t u_mul(input rsel_t d, input rsel_t a, input rsel_t b, input sh_t s);
    uop_t u;
    u = '{op: OP_MUL, dst: d, src_a: a, src_b: b, sh: s, k: 9'sd0};
    return u;
  endfunction

  function automatic uop_t u_pclr(input kc_t k, input rsel_t a);
    uop_t u;
    u = '{op: OP_PCLR, dst: RG_POLY, src_a: a, src_b: RG_ONE, sh: SH32, k: k};
    return u;
  endfunction

  function automatic uop_t u_pacc(input kc_t k, input rsel_t a);
    uop_t u;
    u = '{op: OP_PACC, dst: RG_POLY, src_a: a, src_b: RG_ONE, sh: SH32, k: k};
    return u;
  endfunction

  function automatic uop_t u_sadd(input rsel_t d, input rsel_t a, input rsel_t b);
    uop_t u;
    u = '{op: OP_SADD, dst: d, src_a: a, src_b: b, sh: SH32, k: 9'sd0};
    return u;
  endfunction

  function automatic uop_t u_clmp();
    uop_t u;
    u = '{op: OP_CLMP, dst: RG_S1, src_a: RG_S1, src_b: RG_ONE, sh: SH32, k: 9'sd0};
    return u;
  endfunction

  // step program: time powers, scaled terms, then position, velocity, acceleration
  function automatic uop_t ucode(input upc_t pc);
    uop_t u;
    case (pc)
      6'd0:  u = u_mul(RG_S1, RG_DT, RG_RCP, SH30);
      6'd1:  u = u_clmp();
      6'd2:  u = u_mul(RG_S2, RG_S1, RG_S1, SH32);
      6'd3:  u = u_mul(RG_S3, RG_S2, RG_S1, SH32);
      6'd4:  u = u_mul(RG_S4, RG_S3, RG_S1, SH32);
      6'd5:  u = u_mul(RG_S5, RG_S4, RG_S1, SH32);
      6'd6:  u = u_mul(RG_A, RG_T1, RG_TAU, SH16);
      6'd7:  u = u_mul(RG_T2, RG_T2, RG_TAU, SH16);
      6'd8:  u = u_mul(RG_B, RG_T2, RG_TAU, SH17);
      6'd9:  u = u_pclr(9'sd6, RG_S5);
      6'd10: u = u_pacc(-9'sd15, RG_S4);
      6'd11: u = u_pacc(9'sd10, RG_S3);
      6'd12: u = u_mul(RG_ACC, RG_D, RG_POLY, SH32);
      6'd13: u = u_pclr(-9'sd3, RG_S5);
      6'd14: u = u_pacc(9'sd8, RG_S4);
      6'd15: u = u_pacc(-9'sd6, RG_S3);
      6'd16: u = u_pacc(9'sd1, RG_S1);
      6'd17: u = u_mul(RG_T1, RG_A, RG_POLY, SH32);
      6'd18: u = u_sadd(RG_ACC, RG_ACC, RG_T1);
      6'd19: u = u_pclr(-9'sd1, RG_S5);
      6'd20: u = u_pacc(9'sd3, RG_S4);
      6'd21: u = u_pacc(-9'sd3, RG_S3);
      6'd22: u = u_pacc(9'sd1, RG_S2);
      6'd23: u = u_mul(RG_T1, RG_B, RG_POLY, SH32);
      6'd24: u = u_sadd(RG_ACC, RG_ACC, RG_T1);
      6'd25: u = u_sadd(RG_P, RG_P, RG_ACC);
      6'd26: u = u_pclr(9'sd30, RG_S4);
      6'd27: u = u_pacc(-9'sd60, RG_S3);
      6'd28: u = u_pacc(9'sd30, RG_S2);
      6'd29: u = u_mul(RG_ACC, RG_D, RG_POLY, SH32);
      6'd30: u = u_pclr(-9'sd15, RG_S4);
      6'd31: u = u_pacc(9'sd32, RG_S3);
      6'd32: u = u_pacc(-9'sd18, RG_S2);
      6'd33: u = u_pacc(9'sd1, RG_ONE);
      6'd34: u = u_mul(RG_T1, RG_A, RG_POLY, SH32);
      6'd35: u = u_sadd(RG_ACC, RG_ACC, RG_T1);
      6'd36: u = u_pclr(-9'sd5, RG_S4);
      6'd37: u = u_pacc(9'sd12, RG_S3);
      6'd38: u = u_pacc(-9'sd9, RG_S2);
      6'd39: u = u_pacc(9'sd2, RG_S1);
      6'd40: u = u_mul(RG_T1, RG_B, RG_POLY, SH32);
      6'd41: u = u_sadd(RG_ACC, RG_ACC, RG_T1);
      6'd42: u = u_mul(RG_T2, RG_ACC, RG_RCP, SH46);
      6'd43: u = u_pclr(9'sd120, RG_S3);
      6'd44: u = u_pacc(-9'sd180, RG_S2);
      6'd45: u = u_pacc(9'sd60, RG_S1);
      6'd46: u = u_mul(RG_ACC, RG_D, RG_POLY, SH32);
      6'd47: u = u_pclr(-9'sd60, RG_S3);
      6'd48: u = u_pacc(9'sd96, RG_S2);
      6'd49: u = u_pacc(-9'sd36, RG_S1);
      6'd50: u = u_mul(RG_T1, RG_A, RG_POLY, SH32);
      6'd51: u = u_sadd(RG_ACC, RG_ACC, RG_T1);
      6'd52: u = u_pclr(-9'sd20, RG_S3);
      6'd53: u = u_pacc(9'sd36, RG_S2);
      6'd54: u = u_pacc(-9'sd18, RG_S1);
      6'd55: u = u_pacc(9'sd2, RG_ONE);
      6'd56: u = u_mul(RG_T1, RG_B, RG_POLY, SH32);
      6'd57: u = u_sadd(RG_ACC, RG_ACC, RG_T1);
      6'd58: u = u_mul(RG_ACC, RG_ACC, RG_RCP, SH46);
      6'd59: u = u_mul(RG_ACC, RG_ACC, RG_RCP, SH46);
      default: u = u_pacc(9'sd0, RG_ONE);
    endcase
    return u;
  endfunction

endpackage

>>> sv/mjs_if.sv
`timescale 1ns / 1ps
interface mjs_in_if;
  logic          valid;
  logic          ready;
  logic          action;
  mjs_pkg::axis_t axis;
  mjs_pkg::q16_t start_position;
  mjs_pkg::q16_t goal_position;

  modport source(output valid, action, axis, start_position, goal_position, input ready);
  modport sink(input valid, action, axis, start_position, goal_position, output ready);
endinterface

interface mjs_out_if;
  logic           valid;
  logic           ready;
  mjs_pkg::axis_t out_axis;
  mjs_pkg::q16_t  next_position;
  mjs_pkg::q16_t  next_velocity;
  mjs_pkg::q16_t  next_acceleration;
  logic [1:0]     status;
  logic           last;

  modport source(output valid, out_axis, next_position, next_velocity, next_acceleration,
                 status, last, input ready);
  modport sink(input valid, out_axis, next_position, next_velocity, next_acceleration,
               status, last, output ready);
endinterface

>>> sv/mjs_ctrl.sv
`timescale 1ns / 1ps
module mjs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output mjs_pkg::ctl_cmd_t cmd,
  input  mjs_pkg::dp_sts_t  sts
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_READ  = 8'b0000_0010,
    S_TAU   = 8'b0000_0100,
    S_CHECK = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_RUN   = 8'b0010_0000,
    S_MULW  = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t        state_r, state_nxt;
  mjs_pkg::upc_t pc_r, pc_nxt;

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.uop       = mjs_pkg::ucode(pc_r);
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_TAU;
      end
      S_TAU: begin
        cmd.tau   = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.kind == mjs_pkg::KD_STEP_OK) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          pc_nxt    = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.uop_go = 1'b1;
        if (cmd.uop.op == mjs_pkg::OP_MUL) begin
          state_nxt = S_MULW;
        end else if (pc_r == mjs_pkg::UPC_LAST) begin
          state_nxt = S_FIN;
        end else begin
          pc_nxt = pc_r + 6'd1;
        end
      end
      S_MULW: begin
        if (sts.mul_done) begin
          if (pc_r == mjs_pkg::UPC_LAST) begin
            state_nxt = S_FIN;
          end else begin
            pc_nxt    = pc_r + 6'd1;
            state_nxt = S_RUN;
          end
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

endmodule

>>> sv/mjs_dp.sv
`timescale 1ns / 1ps
module mjs_dp #(
  parameter int NUM_AXES = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  mjs_pkg::utime_t        cfg_wdata,
  input  logic                   in_action,
  input  mjs_pkg::axis_t         in_axis,
  input  mjs_pkg::q16_t          in_start_position,
  input  mjs_pkg::q16_t          in_goal_position,
  input  mjs_pkg::ctl_cmd_t      cmd,
  output mjs_pkg::dp_sts_t       sts,
  input  logic                   out_ready,
  output logic                   out_valid,
  output mjs_pkg::axis_t         out_axis,
  output mjs_pkg::q16_t          out_next_position,
  output mjs_pkg::q16_t          out_next_velocity,
  output mjs_pkg::q16_t          out_next_acceleration,
  output logic [1:0]             out_status,
  output logic                   out_last
);

  localparam int IW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam logic [8:0] NUM_AX9 = 9'(NUM_AXES);

  function automatic mjs_pkg::w64_t sx32(input mjs_pkg::q16_t x);
    return {{32{x[31]}}, x};
  endfunction

  function automatic mjs_pkg::w64_t clamp65(input logic signed [64:0] x);
    mjs_pkg::w64_t r;
    if (x > 65'(mjs_pkg::LIM)) r = mjs_pkg::LIM;
    else if (x < -65'(mjs_pkg::LIM)) r = -mjs_pkg::LIM;
    else r = x[63:0];
    return r;
  endfunction

  function automatic mjs_pkg::q16_t sat32(input mjs_pkg::w64_t x);
    mjs_pkg::q16_t r;
    if (x > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (x < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic [63:0] mag64(input mjs_pkg::w64_t x);
    return x[63] ? (64'd0 - 64'(x)) : 64'(x);
  endfunction

  // configuration
  mjs_pkg::utime_t dur_r, dt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r <= mjs_pkg::DUR_RST;
      dt_r  <= mjs_pkg::DT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mjs_pkg::CFG_DURATION:  dur_r <= cfg_wdata;
        mjs_pkg::CFG_STEP_TIME: dt_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // item and per-axis state
  logic           it_act_r;
  mjs_pkg::axis_t it_axis_r;
  mjs_pkg::q16_t  it_sp_r, it_gp_r;

  mjs_pkg::q16_t mem_pos_r [NUM_AXES];
  mjs_pkg::q16_t mem_vel_r [NUM_AXES];
  mjs_pkg::q16_t mem_acc_r [NUM_AXES];
  mjs_pkg::q16_t mem_goal_r [NUM_AXES];
  mjs_pkg::sidx_t mem_idx_r [NUM_AXES];
  logic [NUM_AXES-1:0] act_r;

  mjs_pkg::q16_t  st_p_r, st_v_r, st_a_r, st_g_r;
  mjs_pkg::sidx_t st_idx_r;
  logic           st_act_r;

  logic [8:0]    ax_ext;
  logic [IW-1:0] ix;
  logic          ax_bad;

  assign ax_ext = {6'd0, it_axis_r};
  assign ix     = ax_ext[IW-1:0];
  assign ax_bad = ax_ext >= NUM_AX9;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      it_act_r  <= in_action;
      it_axis_r <= in_axis;
      it_sp_r   <= in_start_position;
      it_gp_r   <= in_goal_position;
    end
    if (cmd.rd) begin
      st_p_r   <= mem_pos_r[ix];
      st_v_r   <= mem_vel_r[ix];
      st_a_r   <= mem_acc_r[ix];
      st_g_r   <= mem_goal_r[ix];
      st_idx_r <= mem_idx_r[ix];
      st_act_r <= act_r[ix];
    end
  end

  // timing checks
  logic [46:0]        idxdt_r;
  logic signed [47:0] tau_c;
  logic [32:0]        dt3;
  mjs_pkg::kind_t     kind_c, kind_r;
  logic               last_c, last_r;

  always_ff @(posedge clk) begin
    if (cmd.tau) idxdt_r <= 47'(st_idx_r) * 47'(dt_r);
  end

  assign tau_c = $signed({17'd0, dur_r}) - $signed({1'b0, idxdt_r});
  assign dt3   = {2'd0, dt_r} + {1'b0, dt_r, 1'b0};

  always_comb begin
    kind_c = mjs_pkg::KD_NO_AXIS;
    last_c = 1'b0;
    if (ax_bad) begin
      kind_c = mjs_pkg::KD_NO_AXIS;
    end else if (it_act_r == mjs_pkg::ACT_LOAD) begin
      last_c = {1'b0, dur_r} < {dt_r, 1'b0};
      if (dt_r == '0 || dur_r == '0 || dt_r > dur_r) kind_c = mjs_pkg::KD_LOAD_BAD;
      else kind_c = mjs_pkg::KD_LOAD_OK;
    end else if (!st_act_r) begin
      kind_c = mjs_pkg::KD_STEP_IDLE;
    end else begin
      last_c = (tau_c < $signed({15'd0, dt3})) || (st_idx_r >= mjs_pkg::IDX_CAP);
      if (dt_r == '0 || tau_c <= 48'sd0 || $signed({17'd0, dt_r}) > tau_c)
        kind_c = mjs_pkg::KD_STEP_BAD;
      else
        kind_c = mjs_pkg::KD_STEP_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      kind_r <= kind_c;
      last_r <= last_c;
    end
  end

  // working registers
  mjs_pkg::w64_t rg_rcp_r, rg_s1_r, rg_s2_r, rg_s3_r, rg_s4_r, rg_s5_r;
  mjs_pkg::w64_t rg_d_r, rg_a_r, rg_b_r, rg_p_r, rg_tau_r, rg_dt_r;
  mjs_pkg::w64_t rg_acc_r, rg_poly_r, rg_t1_r, rg_t2_r;
  mjs_pkg::w64_t opa, opb;

  always_comb begin
    case (cmd.uop.src_a)
      mjs_pkg::RG_RCP:  opa = rg_rcp_r;
      mjs_pkg::RG_S1:   opa = rg_s1_r;
      mjs_pkg::RG_S2:   opa = rg_s2_r;
      mjs_pkg::RG_S3:   opa = rg_s3_r;
      mjs_pkg::RG_S4:   opa = rg_s4_r;
      mjs_pkg::RG_S5:   opa = rg_s5_r;
      mjs_pkg::RG_D:    opa = rg_d_r;
      mjs_pkg::RG_A:    opa = rg_a_r;
      mjs_pkg::RG_B:    opa = rg_b_r;
      mjs_pkg::RG_P:    opa = rg_p_r;
      mjs_pkg::RG_TAU:  opa = rg_tau_r;
      mjs_pkg::RG_DT:   opa = rg_dt_r;
      mjs_pkg::RG_ACC:  opa = rg_acc_r;
      mjs_pkg::RG_POLY: opa = rg_poly_r;
      mjs_pkg::RG_T1:   opa = rg_t1_r;
      mjs_pkg::RG_T2:   opa = rg_t2_r;
      mjs_pkg::RG_ONE:  opa = mjs_pkg::ONE_Q32;
      default:          opa = '0;
    endcase
  end

  always_comb begin
    case (cmd.uop.src_b)
      mjs_pkg::RG_RCP:  opb = rg_rcp_r;
      mjs_pkg::RG_S1:   opb = rg_s1_r;
      mjs_pkg::RG_S2:   opb = rg_s2_r;
      mjs_pkg::RG_S3:   opb = rg_s3_r;
      mjs_pkg::RG_S4:   opb = rg_s4_r;
      mjs_pkg::RG_S5:   opb = rg_s5_r;
      mjs_pkg::RG_D:    opb = rg_d_r;
      mjs_pkg::RG_A:    opb = rg_a_r;
      mjs_pkg::RG_B:    opb = rg_b_r;
      mjs_pkg::RG_P:    opb = rg_p_r;
      mjs_pkg::RG_TAU:  opb = rg_tau_r;
      mjs_pkg::RG_DT:   opb = rg_dt_r;
      mjs_pkg::RG_ACC:  opb = rg_acc_r;
      mjs_pkg::RG_POLY: opb = rg_poly_r;
      mjs_pkg::RG_T1:   opb = rg_t1_r;
      mjs_pkg::RG_T2:   opb = rg_t2_r;
      mjs_pkg::RG_ONE:  opb = mjs_pkg::ONE_Q32;
      default:          opb = '0;
    endcase
  end

  // reciprocal 2^62 / tau, one quotient bit per cycle
  logic        dv_busy_r, dv_done_r;
  logic [5:0]  dv_cnt_r;
  logic [31:0] dv_rem_r;
  logic [62:0] dv_q_r;
  logic [32:0] dv_trial;
  logic        dv_ge;

  assign dv_trial = {dv_rem_r, (dv_cnt_r == 6'd62)};
  assign dv_ge    = dv_trial >= rg_tau_r[32:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r <= 1'b0;
      dv_done_r <= 1'b0;
      dv_cnt_r  <= '0;
    end else begin
      dv_done_r <= 1'b0;
      if (cmd.div_start) begin
        dv_busy_r <= 1'b1;
        dv_cnt_r  <= 6'd62;
      end else if (dv_busy_r) begin
        dv_cnt_r <= dv_cnt_r - 6'd1;
        if (dv_cnt_r == '0) begin
          dv_busy_r <= 1'b0;
          dv_done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dv_rem_r <= '0;
      dv_q_r   <= '0;
    end else if (dv_busy_r) begin
      dv_rem_r <= dv_ge ? 32'(dv_trial - rg_tau_r[32:0]) : dv_trial[31:0];
      dv_q_r   <= {dv_q_r[61:0], dv_ge};
    end
  end

  // shared multiplier: four 32x32 partial products, then shift and saturate
  logic          mu_busy_r;
  logic [2:0]    mu_cnt_r;
  logic [63:0]   mu_a_r, mu_b_r;
  logic          mu_neg_r;
  mjs_pkg::sh_t  mu_sh_r;
  mjs_pkg::rsel_t mu_dst_r;
  logic [127:0]  mu_prod_r;
  logic [31:0]   mu_pa, mu_pb;
  logic [63:0]   mu_pp;
  logic [127:0]  mu_add, mu_q;
  logic [63:0]   mu_mag;
  mjs_pkg::w64_t mu_res;
  logic          mu_done;
  logic          mu_go;

  assign mu_go   = cmd.uop_go && (cmd.uop.op == mjs_pkg::OP_MUL);
  assign mu_done = mu_busy_r && (mu_cnt_r == 3'd4);
  assign mu_pa   = mu_cnt_r[1] ? mu_a_r[63:32] : mu_a_r[31:0];
  assign mu_pb   = mu_cnt_r[0] ? mu_b_r[63:32] : mu_b_r[31:0];
  assign mu_pp   = 64'(mu_pa) * 64'(mu_pb);

  always_comb begin
    case (mu_cnt_r[1:0])
      2'd0:    mu_add = {64'd0, mu_pp};
      2'd3:    mu_add = {mu_pp, 64'd0};
      default: mu_add = {32'd0, mu_pp, 32'd0};
    endcase
  end

  always_comb begin
    case (mu_sh_r)
      mjs_pkg::SH16: mu_q = mu_prod_r >> 16;
      mjs_pkg::SH17: mu_q = mu_prod_r >> 17;
      mjs_pkg::SH30: mu_q = mu_prod_r >> 30;
      mjs_pkg::SH32: mu_q = mu_prod_r >> 32;
      mjs_pkg::SH46: mu_q = mu_prod_r >> 46;
      default:       mu_q = mu_prod_r;
    endcase
    mu_mag = (|mu_q[127:62]) ? 64'(mjs_pkg::LIM) : {2'd0, mu_q[61:0]};
    mu_res = mu_neg_r ? $signed(64'd0 - mu_mag) : $signed(mu_mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_busy_r <= 1'b0;
      mu_cnt_r  <= '0;
    end else if (mu_go) begin
      mu_busy_r <= 1'b1;
      mu_cnt_r  <= '0;
    end else if (mu_done) begin
      mu_busy_r <= 1'b0;
    end else if (mu_busy_r) begin
      mu_cnt_r <= mu_cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (mu_go) begin
      mu_a_r    <= mag64(opa);
      mu_b_r    <= mag64(opb);
      mu_neg_r  <= opa[63] ^ opb[63];
      mu_sh_r   <= cmd.uop.sh;
      mu_dst_r  <= cmd.uop.dst;
      mu_prod_r <= '0;
    end else if (mu_busy_r && !mu_done) begin
      mu_prod_r <= mu_prod_r + mu_add;
    end
  end

  // operations outside the multiplier: poly terms, saturating add, clamp
  logic signed [72:0] pk_term;
  mjs_pkg::w64_t      pk_base, alu_res;
  logic               wr_en;
  mjs_pkg::rsel_t     wr_sel;
  mjs_pkg::w64_t      wr_data;

  assign pk_term = opa * cmd.uop.k;
  assign pk_base = (cmd.uop.op == mjs_pkg::OP_PCLR) ? 64'sd0 : rg_poly_r;

  always_comb begin
    case (cmd.uop.op)
      mjs_pkg::OP_PCLR, mjs_pkg::OP_PACC: alu_res = pk_base + pk_term[63:0];
      mjs_pkg::OP_SADD:
        alu_res = clamp65(65'(clamp65(65'(opa))) + 65'(clamp65(65'(opb))));
      mjs_pkg::OP_CLMP: alu_res = (opa > mjs_pkg::ONE_Q32) ? mjs_pkg::ONE_Q32 : opa;
      default:          alu_res = opa;
    endcase
    if (mu_done) begin
      wr_en   = 1'b1;
      wr_sel  = mu_dst_r;
      wr_data = mu_res;
    end else begin
      wr_en   = cmd.uop_go && (cmd.uop.op != mjs_pkg::OP_MUL);
      wr_sel  = cmd.uop.dst;
      wr_data = alu_res;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      rg_tau_r <= 64'(tau_c);
      rg_dt_r  <= {33'd0, dt_r};
      rg_d_r   <= sx32(st_g_r) - sx32(st_p_r);
      rg_p_r   <= sx32(st_p_r);
      rg_t1_r  <= sx32(st_v_r);
      rg_t2_r  <= sx32(st_a_r);
    end
    if (dv_done_r) rg_rcp_r <= {1'b0, dv_q_r};
    if (wr_en) begin
      case (wr_sel)
        mjs_pkg::RG_RCP:  rg_rcp_r  <= wr_data;
        mjs_pkg::RG_S1:   rg_s1_r   <= wr_data;
        mjs_pkg::RG_S2:   rg_s2_r   <= wr_data;
        mjs_pkg::RG_S3:   rg_s3_r   <= wr_data;
        mjs_pkg::RG_S4:   rg_s4_r   <= wr_data;
        mjs_pkg::RG_S5:   rg_s5_r   <= wr_data;
        mjs_pkg::RG_D:    rg_d_r    <= wr_data;
        mjs_pkg::RG_A:    rg_a_r    <= wr_data;
        mjs_pkg::RG_B:    rg_b_r    <= wr_data;
        mjs_pkg::RG_P:    rg_p_r    <= wr_data;
        mjs_pkg::RG_TAU:  rg_tau_r  <= wr_data;
        mjs_pkg::RG_DT:   rg_dt_r   <= wr_data;
        mjs_pkg::RG_ACC:  rg_acc_r  <= wr_data;
        mjs_pkg::RG_POLY: rg_poly_r <= wr_data;
        mjs_pkg::RG_T1:   rg_t1_r   <= wr_data;
        mjs_pkg::RG_T2:   rg_t2_r   <= wr_data;
        default: ;
      endcase
    end
  end

  // result and state commit
  mjs_pkg::q16_t np, nv, na;

  assign np = sat32(rg_p_r);
  assign nv = sat32(rg_t2_r);
  assign na = sat32(rg_acc_r);

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      case (kind_r)
        mjs_pkg::KD_LOAD_OK: begin
          mem_pos_r[ix]  <= it_sp_r;
          mem_vel_r[ix]  <= '0;
          mem_acc_r[ix]  <= '0;
          mem_goal_r[ix] <= it_gp_r;
          mem_idx_r[ix]  <= '0;
        end
        mjs_pkg::KD_STEP_OK: begin
          mem_pos_r[ix] <= np;
          mem_vel_r[ix] <= nv;
          mem_acc_r[ix] <= na;
          mem_idx_r[ix] <= st_idx_r + 16'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
    end else if (cmd.fin) begin
      case (kind_r)
        mjs_pkg::KD_LOAD_OK, mjs_pkg::KD_STEP_OK: act_r[ix] <= !last_r;
        mjs_pkg::KD_LOAD_BAD, mjs_pkg::KD_STEP_BAD: act_r[ix] <= 1'b0;
        default: ;
      endcase
    end
  end

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_axis              <= it_axis_r;
      out_next_position     <= '0;
      out_next_velocity     <= '0;
      out_next_acceleration <= '0;
      out_last              <= 1'b0;
      case (kind_r)
        mjs_pkg::KD_LOAD_OK: begin
          out_next_position <= it_sp_r;
          out_status        <= mjs_pkg::ST_OK;
          out_last          <= last_r;
        end
        mjs_pkg::KD_STEP_OK: begin
          out_next_position     <= np;
          out_next_velocity     <= nv;
          out_next_acceleration <= na;
          out_status            <= mjs_pkg::ST_OK;
          out_last              <= last_r;
        end
        mjs_pkg::KD_LOAD_BAD, mjs_pkg::KD_STEP_BAD: out_status <= mjs_pkg::ST_TIMING;
        default: out_status <= mjs_pkg::ST_NO_MOVE;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.kind     = kind_c;
  assign sts.div_done = dv_done_r;
  assign sts.mul_done = mu_done;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

>>> sv/min_jerk_setpoint_generator_unit.sv
`timescale 1ns / 1ps
// channel   dir  beat                                                       
// in_ch     in   action, axis, start_position, goal_position                
// out_ch    out  out_axis, next_position/velocity/acceleration, status, last
// cfg_*     in   cfg_we, cfg_index, cfg_wdata (one write per clock)         
//
// one item at a time; a load or any rejected item goes through read, tau and check to out_ch
// a step also waits on the 2^62/tau divider, then runs 20 products on the shared 32x32
// multiplier and 40 poly, add and clamp ops
// in_ch is ready again as soon as a result is parked in the output register
// synchronous active-low reset clears control and the per-axis active flags
module min_jerk_setpoint_generator_unit #(
  parameter int NUM_AXES = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  mjs_in_if.sink          in_ch,
  mjs_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  mjs_pkg::utime_t cfg_wdata
);

  mjs_pkg::ctl_cmd_t cmd;
  mjs_pkg::dp_sts_t  sts;

  mjs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  mjs_dp #(.NUM_AXES(NUM_AXES)) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_action             (in_ch.action),
    .in_axis               (in_ch.axis),
    .in_start_position     (in_ch.start_position),
    .in_goal_position      (in_ch.goal_position),
    .cmd                   (cmd),
    .sts                   (sts),
    .out_ready             (out_ch.ready),
    .out_valid             (out_ch.valid),
    .out_axis              (out_ch.out_axis),
    .out_next_position     (out_ch.next_position),
    .out_next_velocity     (out_ch.next_velocity),
    .out_next_acceleration (out_ch.next_acceleration),
    .out_status            (out_ch.status),
    .out_last              (out_ch.last)
  );

endmodule

>>> sv/mjs_checker.sv
`timescale 1ns / 1ps
module mjs_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input mjs_pkg::q16_t out_pos,
  input mjs_pkg::q16_t out_vel,
  input mjs_pkg::q16_t out_acc,
  input logic [1:0]    out_status,
  input logic          out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable({out_pos, out_vel, out_acc, out_status, out_last}))
    else $error("stalled result beat changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != mjs_pkg::ST_OK |->
      out_pos == '0 && out_vel == '0 && out_acc == '0 && !out_last)
    else $error("error beat carries values");

  a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_status == mjs_pkg::ST_OK)
    else $error("last on error beat");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

endmodule

bind min_jerk_setpoint_generator_unit mjs_checker u_mjs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_pos    (out_ch.next_position),
  .out_vel    (out_ch.next_velocity),
  .out_acc    (out_ch.next_acceleration),
  .out_status (out_ch.status),
  .out_last   (out_ch.last)
);
